// ===== rtl/chsd_pkg.sv =====
// Shared types and codes for the canonical Huffman stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package chsd_pkg;

  localparam int unsigned MaxCodeBits = 15;
  localparam int unsigned MaxCodes    = 256;
  localparam int unsigned TableDepth  = 1 << MaxCodeBits;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic [3:0] nbits;
  } item_t;

  localparam logic [3:0] PH_VERSION = 4'd0;
  localparam logic [3:0] PH_CHUNK   = 4'd1;
  localparam logic [3:0] PH_MAXLEN  = 4'd2;
  localparam logic [3:0] PH_COUNTN  = 4'd3;
  localparam logic [3:0] PH_COUNTS  = 4'd4;
  localparam logic [3:0] PH_SYMBOLS = 4'd5;
  localparam logic [3:0] PH_DECODE  = 4'd6;
  localparam logic [3:0] PH_STOPPED = 4'd7;

  localparam logic [2:0] ST_SYMBOL    = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_BAD_CHUNK = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_BAD_CNT   = 3'd5;
  localparam logic [2:0] ST_TOO_MANY  = 3'd6;
  localparam logic [2:0] ST_TRUNC     = 3'd7;

endpackage
`default_nettype wire

// ===== rtl/chsd_front.sv =====
// Input side: accepts items, resolves valid bit count, two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module chsd_front import chsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_stream_byte,
  input  wire logic       in_final_byte,
  input  wire logic [3:0] in_final_bits,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);

  item_t      mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  item_t      cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.data  = in_stream_byte;
    cls.fin   = in_final_byte;
    if (!in_final_byte) begin
      cls.nbits = 4'd8;
    end else if (in_final_bits > 4'd8) begin
      cls.nbits = 4'd8;
    end else begin
      cls.nbits = in_final_bits;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chsd_engine.sv =====
// Back end: header and table parser, prefix table memory, symbol decode.
`timescale 1ns / 1ps
`default_nettype none
module chsd_engine import chsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_symbol,
  output logic [2:0]      out_status,
  output logic            out_run_end
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RUN  = 6'b000010,
    S_FILL = 6'b000100,
    S_LOOK = 6'b001000,
    S_END  = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t      state_r;
  logic [31:0] buf_r;
  logic [5:0]  bc_r;
  logic [3:0]  phase_r;
  logic [25:0] chunk_len_r;
  logic [3:0]  max_len_r;
  logic [3:0]  tcl_r;
  logic [15:0] counts_r [16];
  logic [4:0]  ci_r;
  logic [8:0]  codes_r;
  logic [15:0] prev_code_r;
  logic [3:0]  prev_len_r;
  logic [25:0] se_r;
  logic [3:0]  syms_r;
  logic        fin_r;
  logic [2:0]  st_r;
  logic        err_r;
  logic        pend_v_r;
  logic [7:0]  pend_sym_r;
  logic [14:0] fill_idx_r;
  logic [15:0] fill_left_r;
  logic [11:0] fill_ent_r;
  logic [11:0] mem_rd_r;
  logic [11:0] tbl_mem [TableDepth];

  logic        out_valid_r;
  logic [7:0]  out_symbol_r;
  logic [2:0]  out_status_r;
  logic        out_run_end_r;
  logic        out_free;
  logic        out_load;

  logic [15:0] tk8;
  logic [15:0] tk16;
  logic [31:0] rest8;
  logic [31:0] rest16;
  logic [3:0]  clen;
  logic [3:0]  dsh;
  logic [15:0] code;
  logic [3:0]  shift;
  logic [30:0] base_w;
  logic [31:0] idx_w;
  logic [14:0] rd_idx;
  logic        rd_en;
  logic [3:0]  ent_len;
  logic [5:0]  eff;
  logic [5:0]  bc_after;
  logic [31:0] rest_eff;
  logic [2:0]  end_st;
  logic [5:0]  bc_app;

  function automatic logic [15:0] tval(logic [31:0] b, logic [5:0] c, logic [5:0] n);
    logic [31:0] s;
    s = b >> (c - n);
    return s[15:0] & ((16'h1 << n[4:0]) - 16'h1);
  endfunction

  function automatic logic [31:0] keep(logic [31:0] b, logic [5:0] c);
    return b & ((32'h1 << c[4:0]) - 32'h1);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free &&
                    (((state_r == S_HOLD || state_r == S_END) && pend_v_r) ||
                     (state_r == S_END && !pend_v_r && st_r != ST_SYMBOL));
  assign out_valid   = out_valid_r;
  assign out_symbol  = out_symbol_r;
  assign out_status  = out_status_r;
  assign out_run_end = out_run_end_r;
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    tk8    = tval(buf_r, bc_r, 6'd8);
    tk16   = tval(buf_r, bc_r, 6'd16);
    rest8  = keep(buf_r, bc_r - 6'd8);
    rest16 = keep(buf_r, bc_r - 6'd16);
    clen   = ci_r[3:0];
    dsh    = (clen >= prev_len_r) ? (clen - prev_len_r) : 4'd0;
    code   = (codes_r != 9'd0) ? ((prev_code_r + 16'd1) << dsh) : 16'd0;
    shift  = (tcl_r >= clen) ? (tcl_r - clen) : 4'd0;
    base_w = {15'd0, code} << shift;
    if (bc_r >= {2'b00, tcl_r}) begin
      idx_w = buf_r >> (bc_r - {2'b00, tcl_r});
    end else begin
      idx_w = buf_r << ({2'b00, tcl_r} - bc_r);
    end
    rd_idx = idx_w[14:0] & ((15'h1 << tcl_r) - 15'h1);
    rd_en  = (state_r == S_RUN) && (phase_r == PH_DECODE) && (se_r < chunk_len_r)
             && (tcl_r != 4'd0) && (syms_r < 4'd8);
    ent_len  = mem_rd_r[11:8];
    eff      = (ent_len == 4'd0) ? 6'd1 : {2'b00, ent_len};
    bc_after = bc_r - eff;
    rest_eff = keep(buf_r, bc_after);
    if (!fin_r) begin
      end_st = ST_SYMBOL;
    end else if (bc_r == 6'd0 && (phase_r == PH_COUNTN || phase_r == PH_DECODE)) begin
      end_st = ST_DONE;
    end else begin
      end_st = ST_TRUNC;
    end
    bc_app = bc_r + {2'b00, q_item.nbits};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      tbl_mem[fill_idx_r] <= fill_ent_r;
    end
    if (rd_en) begin
      mem_rd_r <= tbl_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= 32'd0;
      bc_r        <= 6'd0;
      phase_r     <= PH_VERSION;
      chunk_len_r <= 26'd0;
      max_len_r   <= 4'd0;
      tcl_r       <= 4'd0;
      ci_r        <= 5'd0;
      codes_r     <= 9'd0;
      prev_code_r <= 16'd0;
      prev_len_r  <= 4'd0;
      se_r        <= 26'd0;
      syms_r      <= 4'd0;
      fin_r       <= 1'b0;
      st_r        <= ST_SYMBOL;
      err_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      fill_left_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (phase_r == PH_STOPPED) begin
              if (q_item.fin) begin
                buf_r       <= 32'd0;
                bc_r        <= 6'd0;
                phase_r     <= PH_VERSION;
                chunk_len_r <= 26'd0;
                max_len_r   <= 4'd0;
                tcl_r       <= 4'd0;
                ci_r        <= 5'd0;
                codes_r     <= 9'd0;
                prev_code_r <= 16'd0;
                prev_len_r  <= 4'd0;
                se_r        <= 26'd0;
              end
            end else begin
              if (q_item.nbits != 4'd0 && bc_app <= 6'd32) begin
                buf_r <= (buf_r << q_item.nbits) |
                         {24'd0, q_item.data >> (4'd8 - q_item.nbits)};
                bc_r  <= bc_app;
              end
              fin_r   <= q_item.fin;
              syms_r  <= 4'd0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          priority case (phase_r)
            PH_VERSION: begin
              if (bc_r < 6'd8) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd8; buf_r <= rest8;
                if (tk8 != 16'd1) begin
                  st_r <= ST_BAD_VER; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  phase_r <= PH_CHUNK;
                end
              end
            end
            PH_CHUNK: begin
              if (bc_r < 6'd16) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd16; buf_r <= rest16;
                if (tk16 == 16'd0) begin
                  st_r <= ST_BAD_CHUNK; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  chunk_len_r <= {tk16, 10'd0};
                  phase_r     <= PH_MAXLEN;
                end
              end
            end
            PH_MAXLEN: begin
              if (bc_r < 6'd8) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd8; buf_r <= rest8;
                if (tk8 == 16'd0 || tk8 > 16'(MaxCodeBits)) begin
                  st_r <= ST_BAD_LEN; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  max_len_r <= tk8[3:0];
                  phase_r   <= PH_COUNTN;
                end
              end
            end
            PH_COUNTN: begin
              if (bc_r < 6'd8) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd8; buf_r <= rest8;
                if (tk8 == 16'd0 || tk8 > {11'd0, {1'b0, max_len_r} + 5'd1}) begin
                  st_r <= ST_BAD_CNT; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  tcl_r   <= tk8[3:0] - 4'd1;
                  ci_r    <= 5'd0;
                  codes_r <= 9'd0;
                  phase_r <= PH_COUNTS;
                end
              end
            end
            PH_COUNTS: begin
              if (bc_r < 6'd16) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd16; buf_r <= rest16;
                if (ci_r == 5'd0 && tk16 != 16'd0) begin
                  st_r <= ST_BAD_CNT; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  counts_r[clen] <= tk16;
                  if (ci_r + 5'd1 > {1'b0, tcl_r}) begin
                    ci_r    <= 5'd0;
                    phase_r <= PH_SYMBOLS;
                  end else begin
                    ci_r <= ci_r + 5'd1;
                  end
                end
              end
            end
            PH_SYMBOLS: begin
              if (ci_r > {1'b0, tcl_r}) begin
                se_r    <= 26'd0;
                phase_r <= PH_DECODE;
              end else if (counts_r[clen] == 16'd0) begin
                ci_r <= ci_r + 5'd1;
              end else if (bc_r < 6'd8) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                bc_r <= bc_r - 6'd8; buf_r <= rest8;
                if (codes_r >= 9'(MaxCodes)) begin
                  st_r <= ST_TOO_MANY; err_r <= 1'b1; state_r <= S_END;
                end else begin
                  fill_idx_r     <= base_w[14:0];
                  fill_left_r    <= 16'h1 << shift;
                  fill_ent_r     <= {clen, tk8[7:0]};
                  prev_code_r    <= code;
                  prev_len_r     <= clen;
                  codes_r        <= codes_r + 9'd1;
                  counts_r[clen] <= counts_r[clen] - 16'd1;
                  state_r        <= S_FILL;
                end
              end
            end
            PH_DECODE: begin
              if (se_r >= chunk_len_r) begin
                phase_r <= PH_COUNTN;
              end else if (tcl_r == 4'd0) begin
                if (bc_r != 6'd0) begin
                  st_r <= ST_BAD_CNT; err_r <= 1'b1;
                end else begin
                  st_r <= end_st; err_r <= 1'b0;
                end
                state_r <= S_END;
              end else if (syms_r >= 4'd8) begin
                st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
              end else begin
                state_r <= S_LOOK;
              end
            end
            default: begin
              st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
            end
          endcase
        end
        S_FILL: begin
          fill_idx_r  <= fill_idx_r + 15'd1;
          fill_left_r <= fill_left_r - 16'd1;
          if (fill_left_r == 16'd1) begin
            state_r <= S_RUN;
          end
        end
        S_LOOK: begin
          if (eff > bc_r || (ent_len == 4'd0 && bc_r < {2'b00, tcl_r})) begin
            st_r <= end_st; err_r <= 1'b0; state_r <= S_END;
          end else begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_valid_r   <= 1'b1;
              out_symbol_r  <= pend_sym_r;
              out_status_r  <= ST_SYMBOL;
              out_run_end_r <= 1'b0;
            end
            pend_v_r   <= 1'b1;
            pend_sym_r <= mem_rd_r[7:0];
            bc_r       <= bc_after;
            buf_r      <= rest_eff;
            syms_r     <= syms_r + 4'd1;
            se_r       <= se_r + 26'd1;
            state_r    <= S_RUN;
          end
        end
        S_END: begin
          if (pend_v_r) begin
            if (out_free) begin
              out_valid_r   <= 1'b1;
              out_symbol_r  <= pend_sym_r;
              out_status_r  <= ST_SYMBOL;
              out_run_end_r <= (st_r == ST_SYMBOL);
              pend_v_r      <= 1'b0;
            end
          end else if (st_r == ST_SYMBOL || out_free) begin
            if (st_r != ST_SYMBOL) begin
              out_valid_r   <= 1'b1;
              out_symbol_r  <= 8'd0;
              out_status_r  <= st_r;
              out_run_end_r <= 1'b1;
            end
            if (fin_r) begin
              buf_r       <= 32'd0;
              bc_r        <= 6'd0;
              phase_r     <= PH_VERSION;
              chunk_len_r <= 26'd0;
              max_len_r   <= 4'd0;
              tcl_r       <= 4'd0;
              ci_r        <= 5'd0;
              codes_r     <= 9'd0;
              prev_code_r <= 16'd0;
              prev_len_r  <= 4'd0;
              se_r        <= 26'd0;
            end else if (err_r) begin
              phase_r <= PH_STOPPED;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_bc_range: assert property (@(posedge clk) disable iff (!rst_n) bc_r <= 6'd32)
    else $error("bit count above buffer size");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> fill_left_r != 16'd0)
    else $error("table fill with empty span");
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("held symbol left over at item end");
`endif

endmodule
`default_nettype wire

// ===== rtl/canonical_huffman_stream_decoder_top.sv =====
// Top level of the canonical Huffman stream decoder.
// Usage:
//   in_* channel: one encoded byte per item, MSB first; in_final_byte marks
//   the last byte and in_final_bits its leading valid bits.
//   out_* channel: decoded symbols (status 0) followed, on a final byte or
//   an error, by one status item; out_run_end marks the last result of an
//   input item. Valid/stall handshake on both sides.
//   A two-item queue takes input while the decoder works, and an output
//   register holds a result while the receiver stalls; a stall on the
//   output only halts the decoder when a new result must be written.
//   Per item: the decoder loads the item, takes one step per header or count
//   field or skipped empty length, passes each decoded symbol through table
//   read, length check and consume in turn, and then finishes; while a code
//   is spread it writes one prefix table entry per cycle, up to 2^14 entries
//   for a short code. The prefix table, filled and read in turn, and the
//   parse loop set the rate.
//   Synchronous reset returns to waiting for a version byte; the prefix
//   table and length counts are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none
module canonical_huffman_stream_decoder_top import chsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_stream_byte,
  input  wire logic       in_final_byte,
  input  wire logic [3:0] in_final_bits,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_symbol,
  output logic [2:0]      out_status,
  output logic            out_run_end
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  chsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .in_final_byte  (in_final_byte),
    .in_final_bits  (in_final_bits),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  chsd_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_symbol  (out_symbol),
    .out_status  (out_status),
    .out_run_end (out_run_end)
  );

endmodule
`default_nettype wire

// ===== sim/canonical_huffman_stream_decoder_top_test.sv =====
// Self-checking testbench for the canonical Huffman stream decoder top level.
`timescale 1ns / 1ps
module canonical_huffman_stream_decoder_top_test;
  import chsd_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomItems = 420;

  typedef struct {
    logic [7:0] sym;
    logic [2:0] st;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_stream_byte = 8'd0;
  logic       in_final_byte = 1'b0;
  logic [3:0] in_final_bits = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic [2:0] out_status;
  logic       out_run_end;

  canonical_huffman_stream_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_stream_byte(in_stream_byte),
    .in_final_byte(in_final_byte), .in_final_bits(in_final_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_symbol(out_symbol),
    .out_status(out_status), .out_run_end(out_run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder shadow state
  logic [31:0] held_bits;
  int unsigned held_count, phase_now, chunk_syms, hdr_max, lookup_len;
  int unsigned count_pos, codes_kept, last_code, last_len, syms_done;
  int unsigned len_counts [16];
  logic [11:0] lookup_table [0:TableDepth-1];

  decoded_t    decoded_fifo[$];
  item_t       byte_fifo[$];
  bit          gen_bits[$];
  int unsigned cw_code[$], cw_len[$];

  int unsigned errors = 0, items_sent = 0, results_seen = 0, streams = 0, cycles = 0;
  int unsigned status_seen [8];
  int unsigned multi_left = 2, deep_left = 2, overfull_left = 1;
  int unsigned burst_left = 0, gap_left = 0, stall_mode = 0, stall_span = 0;
  item_t       next_item;

  function automatic int unsigned low_ones(int unsigned n);
    return n >= 32 ? 32'hFFFF_FFFF : (32'd1 << n) - 1;
  endfunction

  function automatic int unsigned pull_bits(int unsigned n);
    int unsigned v;
    v = (held_bits >> (held_count - n)) & low_ones(n);
    held_count -= n;
    held_bits &= low_ones(held_count);
    return v;
  endfunction

  function automatic void restart_stream();
    held_bits = 0; held_count = 0; phase_now = PH_VERSION; chunk_syms = 0;
    hdr_max = 0; lookup_len = 0; count_pos = 0; codes_kept = 0;
    last_code = 0; last_len = 0; syms_done = 0;
  endfunction

  function automatic void spread_code(int unsigned sym);
    int unsigned len, code, d, shift, span, base;
    len = count_pos & 15;
    code = 0;
    if (codes_kept != 0) begin
      d = (len >= last_len) ? len - last_len : 0;
      code = ((last_code + 1) << d) & 16'hFFFF;
    end
    shift = (lookup_len >= len) ? lookup_len - len : 0;
    span = 1 << shift;
    base = code << shift;
    for (int unsigned j = 0; j < span; j++)
      lookup_table[(base + j) & (TableDepth - 1)] = {len[3:0], sym[7:0]};
    last_code = code;
    last_len = len;
    codes_kept++;
  endfunction

  function automatic void add_result(logic [7:0] sym, logic [2:0] st);
    decoded_t r;
    r.sym = sym; r.st = st; r.last = 1'b0;
    decoded_fifo.push_back(r);
  endfunction

  // Parses held bits; ST_SYMBOL here means no status arose.
  function automatic logic [2:0] parse_held();
    int unsigned v, ix, len, eff, syms;
    logic [11:0] ent;
    syms = 0;
    while (1) begin
      case (phase_now)
        PH_VERSION: begin
          if (held_count < 8) return ST_SYMBOL;
          if (pull_bits(8) != 1) return ST_BAD_VER;
          phase_now = PH_CHUNK;
        end
        PH_CHUNK: begin
          if (held_count < 16) return ST_SYMBOL;
          v = pull_bits(16);
          if (v == 0) return ST_BAD_CHUNK;
          chunk_syms = v << 10;
          phase_now = PH_MAXLEN;
        end
        PH_MAXLEN: begin
          if (held_count < 8) return ST_SYMBOL;
          v = pull_bits(8);
          if (v == 0 || v > MaxCodeBits) return ST_BAD_LEN;
          hdr_max = v;
          phase_now = PH_COUNTN;
        end
        PH_COUNTN: begin
          if (held_count < 8) return ST_SYMBOL;
          v = pull_bits(8);
          if (v == 0 || v > hdr_max + 1) return ST_BAD_CNT;
          lookup_len = v - 1;
          count_pos = 0;
          codes_kept = 0;
          phase_now = PH_COUNTS;
        end
        PH_COUNTS: begin
          if (held_count < 16) return ST_SYMBOL;
          v = pull_bits(16);
          if (count_pos == 0 && v != 0) return ST_BAD_CNT;
          len_counts[count_pos & 15] = v;
          count_pos++;
          if (count_pos > lookup_len) begin
            count_pos = 0;
            phase_now = PH_SYMBOLS;
          end
        end
        PH_SYMBOLS: begin
          while (count_pos <= lookup_len && len_counts[count_pos & 15] == 0) count_pos++;
          if (count_pos > lookup_len) begin
            syms_done = 0;
            phase_now = PH_DECODE;
          end else begin
            if (held_count < 8) return ST_SYMBOL;
            v = pull_bits(8);
            if (codes_kept >= MaxCodes) return ST_TOO_MANY;
            spread_code(v);
            len_counts[count_pos & 15]--;
          end
        end
        PH_DECODE: begin
          if (syms_done >= chunk_syms) begin
            phase_now = PH_COUNTN;
          end else begin
            if (lookup_len == 0) return held_count > 0 ? ST_BAD_CNT : ST_SYMBOL;
            if (syms >= 8) return ST_SYMBOL;
            if (held_count >= lookup_len) ix = held_bits >> (held_count - lookup_len);
            else ix = held_bits << (lookup_len - held_count);
            ix &= low_ones(lookup_len) & (TableDepth - 1);
            ent = lookup_table[ix];
            len = ent[11:8];
            eff = len != 0 ? len : 1;
            if (eff > held_count || (len == 0 && held_count < lookup_len)) return ST_SYMBOL;
            void'(pull_bits(eff));
            add_result(ent[7:0], ST_SYMBOL);
            syms++;
            syms_done = (syms_done + 1) & 26'h3FF_FFFF;
          end
        end
        default: return ST_SYMBOL;
      endcase
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin, logic [3:0] fbits);
    int unsigned nb, prior_size;
    logic [2:0] st;
    logic [63:0] w;
    prior_size = decoded_fifo.size();
    if (phase_now > PH_DECODE) begin
      if (fin) restart_stream();
      return;
    end
    nb = 8;
    if (fin) nb = fbits > 8 ? 8 : fbits;
    if (nb > 0 && held_count + nb <= 32) begin
      w = ({32'd0, held_bits} << nb) | (64'(b) >> (8 - nb));
      held_bits = w[31:0];
      held_count += nb;
    end
    st = parse_held();
    if (st != ST_SYMBOL) begin
      add_result(8'd0, st);
      phase_now = PH_STOPPED;
    end else if (fin) begin
      if (held_count == 0 && (phase_now == PH_COUNTN || phase_now == PH_DECODE))
        add_result(8'd0, ST_DONE);
      else
        add_result(8'd0, ST_TRUNC);
    end
    if (fin) restart_stream();
    if (decoded_fifo.size() > prior_size) decoded_fifo[decoded_fifo.size() - 1].last = 1'b1;
  endfunction

  // Stream building
  task automatic put_field(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endtask

  task automatic put_junk(int unsigned n);
    repeat (n) gen_bits.push_back($urandom_range(0, 1));
  endtask

  task automatic put_header(int unsigned kib, int unsigned maxl);
    put_field(1, 8);
    put_field(kib, 16);
    put_field(maxl, 8);
  endtask

  // Complete code set with lengths up to tl, so every lookup hits a written entry.
  task automatic put_codebook(int unsigned tl, int unsigned max_splits);
    int unsigned cnt [16];
    int unsigned code, s, l;
    bit hit;
    foreach (cnt[i]) cnt[i] = 0;
    cw_code.delete();
    cw_len.delete();
    cnt[1] = 2;
    if (tl > 1) begin
      repeat ($urandom_range(0, max_splits)) begin
        s = $urandom_range(1, tl - 1);
        hit = 0;
        for (l = s; l < tl && !hit; l++) begin
          if (cnt[l] > 0) begin
            cnt[l]--;
            cnt[l + 1] += 2;
            hit = 1;
          end
        end
      end
    end
    put_field(tl + 1, 8);
    for (l = 0; l <= tl; l++) put_field(cnt[l], 16);
    code = 0;
    for (l = 1; l <= tl; l++) begin
      for (int unsigned k = 0; k < cnt[l]; k++) begin
        put_field($urandom_range(0, 255), 8);
        cw_code.push_back(code);
        cw_len.push_back(l);
        code++;
      end
      code = code << 1;
    end
  endtask

  task automatic put_symbols(int unsigned n);
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(0, cw_code.size() - 1);
      put_field(cw_code[k], cw_len[k]);
    end
  endtask

  // Packs the pending bits into items; an empty final item only on aligned streams.
  task automatic ship(bit empty_tail);
    item_t it;
    int unsigned r;
    while (gen_bits.size() > 8 || (empty_tail && gen_bits.size() > 0)) begin
      for (int i = 7; i >= 0; i--)
        it.data[i] = gen_bits.size() > 0 ? gen_bits.pop_front() : 1'b0;
      it.fin = 1'b0;
      it.nbits = 4'($urandom_range(0, 15));
      byte_fifo.push_back(it);
    end
    r = gen_bits.size();
    it.data = 8'($urandom_range(0, 255));
    for (int unsigned k = 0; k < r; k++) it.data[7 - k] = gen_bits.pop_front();
    it.fin = 1'b1;
    it.nbits = 4'(r);
    if (empty_tail) it.nbits = 4'd0;
    else if (r == 8 && $urandom_range(0, 3) == 0) it.nbits = 4'($urandom_range(9, 15));
    byte_fifo.push_back(it);
    streams++;
  endtask

  function automatic int unsigned pick_len();
    if (deep_left > 0 && $urandom_range(0, 39) == 0) begin
      deep_left--;
      return MaxCodeBits;
    end
    return $urandom_range(0, 9) < 7 ? $urandom_range(1, 4) : $urandom_range(5, 8);
  endfunction

  task automatic good_stream();
    int unsigned tl, e, n;
    tl = pick_len();
    put_header($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(1, 65535),
               $urandom_range(tl, MaxCodeBits));
    put_codebook(tl, tl < 5 ? 6 : 20);
    put_symbols($urandom_range(0, 30));
    e = $urandom_range(0, 9);
    if (e < 3) put_junk($urandom_range(1, 7));
    else if (e < 5) begin
      n = $urandom_range(1, gen_bits.size() - 1);
      gen_bits = gen_bits[0:n - 1];
    end
  endtask

  task automatic multi_chunk_stream();
    put_header(1, $urandom_range(4, MaxCodeBits));
    put_codebook(1, 0);
    put_symbols(1024);
    put_codebook($urandom_range(1, 4), 6);
    put_symbols($urandom_range(0, 10));
  endtask

  task automatic broken_stream(int unsigned kind);
    int unsigned m, v, n;
    m = $urandom_range(1, MaxCodeBits);
    case (kind)
      0: begin
        v = $urandom_range(0, 254);
        put_field(v >= 1 ? v + 1 : v, 8);
      end
      1: begin
        put_field(1, 8);
        put_field(0, 16);
      end
      2: put_header($urandom_range(1, 65535), $urandom_range(0, 1) ? 0 : $urandom_range(16, 255));
      3: begin
        put_header($urandom_range(1, 65535), m);
        put_field($urandom_range(0, 1) ? 0 : $urandom_range(m + 2, 255), 8);
      end
      4: begin
        put_header($urandom_range(1, 65535), m);
        put_field($urandom_range(1, m + 1), 8);
        put_field($urandom_range(1, 65535), 16);
      end
      5: begin
        put_header($urandom_range(1, 65535), m);
        put_field(1, 8);
        put_field(0, 16);
        put_junk($urandom_range(1, 16));
      end
      6: begin
        put_header($urandom_range(1, 65535), MaxCodeBits);
        put_codebook($urandom_range(1, 6), 8);
        n = $urandom_range(1, gen_bits.size() - 1);
        gen_bits = gen_bits[0:n - 1];
        return;
      end
      default: begin
        // more codes than the table may hold
        put_header($urandom_range(1, 65535), $urandom_range(9, MaxCodeBits));
        put_field(10, 8);
        repeat (9) put_field(0, 16);
        put_field($urandom_range(257, 300), 16);
        repeat (257) put_field($urandom_range(0, 255), 8);
      end
    endcase
    put_junk($urandom_range(0, 20));
  endtask

  task automatic build_stimulus();
    int unsigned target, k;
    // directed: header errors, field extremes, empty code list, empty final item
    put_field(0, 8); ship(1);
    put_field(255, 8); ship(0);
    broken_stream(1); gen_bits.delete(); put_field(1, 8); put_field(0, 16); ship(1);
    put_header(65535, 0); ship(0);
    put_header(1, 16); ship(0);
    put_header(1, 3); put_field(0, 8); ship(0);
    put_header(1, 3); put_field(5, 8); ship(0);
    put_header(1, 15); put_field(16, 8); put_field(65535, 16); ship(0);
    put_header(1, 2); put_field(1, 8); put_field(0, 16); put_field(255, 8); ship(0);
    put_header(65535, 15); put_codebook(1, 0); put_symbols(16); ship(1);
    put_header(2, 3); put_codebook(3, 4); put_symbols(5); put_junk(3); ship(0);
    target = RandomItems;
    while (byte_fifo.size() < target) begin
      k = $urandom_range(0, 99);
      if (k < 58) good_stream();
      else if (k < 63 && multi_left > 0) begin
        multi_left--;
        multi_chunk_stream();
      end else if (k < 65 && overfull_left > 0) begin
        overfull_left--;
        broken_stream(7);
      end else broken_stream($urandom_range(0, 6));
      ship($urandom_range(0, 1) == 0 && gen_bits.size() % 8 == 0 && gen_bits.size() > 0);
    end
  endtask

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 20)
      $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      restart_stream();
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_stream_byte, in_final_byte, in_final_bits);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_fifo.size() > 0) begin
          next_item = byte_fifo.pop_front();
          in_stream_byte <= next_item.data;
          in_final_byte <= next_item.fin;
          in_final_bits <= next_item.nbits;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        status_seen[out_status]++;
        if (decoded_fifo.size() == 0) begin
          flag_mismatch($sformatf("unexpected result sym %0h status %0d", out_symbol, out_status));
        end else begin
          want = decoded_fifo.pop_front();
          if (out_symbol !== want.sym || out_status !== want.st || out_run_end !== want.last)
            flag_mismatch($sformatf("got sym %0h st %0d end %0b, want sym %0h st %0d end %0b",
                                    out_symbol, out_status, out_run_end,
                                    want.sym, want.st, want.last));
        end
      end
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(20, 200);
      end
      stall_span--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        default: out_stall <= $urandom_range(0, 9) < 7;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout with %0d results outstanding", decoded_fifo.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (len_counts[i]) len_counts[i] = 0;
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (byte_fifo.size() > 0 || in_valid || decoded_fifo.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d streams, %0d items in, %0d results out (%0d symbols, %0d done, %0d truncated)",
             streams, items_sent, results_seen, status_seen[ST_SYMBOL], status_seen[ST_DONE],
             status_seen[ST_TRUNC]);
    $display("format errors seen: version %0d chunk %0d length %0d counts %0d overfull %0d",
             status_seen[ST_BAD_VER], status_seen[ST_BAD_CHUNK], status_seen[ST_BAD_LEN],
             status_seen[ST_BAD_CNT], status_seen[ST_TOO_MANY]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== canonical_huffman_stream_decoder_top.f =====
rtl/chsd_pkg.sv
rtl/chsd_front.sv
rtl/chsd_engine.sv
rtl/canonical_huffman_stream_decoder_top.sv
sim/canonical_huffman_stream_decoder_top_test.sv
